FILE: sv/tpgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tpgc_pkg;

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;

    // register field widths
    localparam int BASE_BITS  = 24;
    localparam int INC_BITS   = 16;
    localparam int MOVE_BITS  = 8;
    localparam int FIELD_BITS = 6;

    localparam logic [BASE_BITS-1:0] BASE0_RESET = 24'd30000;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_STAGE0_BASE  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STAGE0_INC   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STAGE0_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STAGE1_BASE  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STAGE1_INC   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STAGE1_LIMIT = 3'd5;

    localparam logic SIDE_WHITE = 1'b0;
    localparam logic SIDE_BLACK = 1'b1;
    localparam logic STAGE_ZERO = 1'b0;
    localparam logic STAGE_ONE  = 1'b1;

    localparam int SECONDS_PER_MINUTE = 60;
    localparam int MINUTES_PER_HOUR   = 60;
    localparam int SECONDS_PER_HOUR   = 3600;

    typedef struct packed {
        logic black_move_done;
        logic white_move_done;
    } move_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] shown_hours;
        logic [FIELD_BITS-1:0] shown_minutes;
        logic [FIELD_BITS-1:0] shown_seconds;
        logic                  side_to_move;
        logic                  clock_running;
        logic                  current_stage;
    } shown_t;

    typedef struct packed {
        logic side_to_move;
        logic clock_running;
        logic current_stage;
    } status_t;

endpackage

`default_nettype wire

FILE: sv/tpgc_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tpgc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/tpgc_time_split.sv
`timescale 1ns / 1ps
`default_nettype none

module tpgc_time_split
    import tpgc_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 100,
    parameter int CLOCK_BITS       = 24
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire logic [CLOCK_BITS-1:0] item_time,
    input  wire status_t               item_status,
    tpgc_stream_if.source              shown_out
);

    localparam int MW = CLOCK_BITS + 2;
    localparam int PW = CLOCK_BITS + MW;

    localparam longint unsigned DIV_S = TICKS_PER_SECOND;
    localparam longint unsigned DIV_M = DIV_S * SECONDS_PER_MINUTE;
    localparam longint unsigned DIV_H = DIV_S * SECONDS_PER_HOUR;

    localparam int SHIFT_S = CLOCK_BITS + $clog2(DIV_S);
    localparam int SHIFT_M = CLOCK_BITS + $clog2(DIV_M);
    localparam int SHIFT_H = CLOCK_BITS + $clog2(DIV_H);

    // rounded-up reciprocals, exact for every clock value
    localparam longint unsigned RECIP_S = ((64'd1 << SHIFT_S) + DIV_S - 1) / DIV_S;
    localparam longint unsigned RECIP_M = ((64'd1 << SHIFT_M) + DIV_M - 1) / DIV_M;
    localparam longint unsigned RECIP_H = ((64'd1 << SHIFT_H) + DIV_H - 1) / DIV_H;

    localparam logic [PW-1:0] MUL_S = PW'(RECIP_S);
    localparam logic [PW-1:0] MUL_M = PW'(RECIP_M);
    localparam logic [PW-1:0] MUL_H = PW'(RECIP_H);

    localparam logic [CLOCK_BITS-1:0] SIXTY_S = CLOCK_BITS'(SECONDS_PER_MINUTE);
    localparam logic [CLOCK_BITS-1:0] SIXTY_M = CLOCK_BITS'(MINUTES_PER_HOUR);

    logic          ld1;
    logic          ld2;
    logic          v1_reg;
    logic          out_valid_reg;
    logic [PW-1:0] prod_s_reg;
    logic [PW-1:0] prod_m_reg;
    logic [PW-1:0] prod_h_reg;
    status_t       status1_reg;
    shown_t        out_data_reg;
    shown_t        out_data_next;

    logic [CLOCK_BITS-1:0] total_s;
    logic [CLOCK_BITS-1:0] total_m;
    logic [CLOCK_BITS-1:0] total_h;
    logic [CLOCK_BITS-1:0] sec_full;
    logic [CLOCK_BITS-1:0] min_full;

    assign ld2        = !out_valid_reg || shown_out.ready;
    assign ld1        = !v1_reg || ld2;
    assign item_ready = ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= item_valid;
            end
            if (ld2)
            begin
                out_valid_reg <= v1_reg;
            end
        end
    end

    // reciprocal products
    always_ff @(posedge clk)
    begin
        if (ld1 && item_valid)
        begin
            prod_s_reg  <= PW'(item_time) * MUL_S;
            prod_m_reg  <= PW'(item_time) * MUL_M;
            prod_h_reg  <= PW'(item_time) * MUL_H;
            status1_reg <= item_status;
        end
    end

    always_comb
    begin
        total_s  = CLOCK_BITS'(prod_s_reg >> SHIFT_S);
        total_m  = CLOCK_BITS'(prod_m_reg >> SHIFT_M);
        total_h  = CLOCK_BITS'(prod_h_reg >> SHIFT_H);
        sec_full = total_s - total_m * SIXTY_S;
        min_full = total_m - total_h * SIXTY_M;

        out_data_next.shown_hours   = total_h[FIELD_BITS-1:0];
        out_data_next.shown_minutes = min_full[FIELD_BITS-1:0];
        out_data_next.shown_seconds = sec_full[FIELD_BITS-1:0];
        out_data_next.side_to_move  = status1_reg.side_to_move;
        out_data_next.clock_running = status1_reg.clock_running;
        out_data_next.current_stage = status1_reg.current_stage;
    end

    always_ff @(posedge clk)
    begin
        if (ld2 && v1_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign shown_out.valid = out_valid_reg;
    assign shown_out.data  = out_data_reg;

endmodule

`default_nettype wire

FILE: sv/two_player_game_clock.sv
`timescale 1ns / 1ps
`default_nettype none

// two-player game clock with per-move increment and two time-control stages.
// each transfer on move_in is one tick carrying the black and white buttons;
// each one gives exactly one transfer on shown_out with the hours, minutes and
// seconds of the clock last shown, the side to move, the running flag and the
// stage. one tick is taken every clock cycle unless back-pressure has filled
// the pipeline, and its result passes in order through the clock state
// update, the three reciprocal multipliers that split the shown time into
// seconds, minutes and hours, and the output register. back-pressure on
// shown_out stalls the pipeline stage by stage, so move_in only drops ready
// once all three stages hold results. configuration is a plain write port;
// writing stage0_base_time also reloads both clocks. no clearing pass after
// reset is needed.
module two_player_game_clock
    import tpgc_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 100,
    parameter int CLOCK_BITS       = 24
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    tpgc_stream_if.sink                    move_in,
    tpgc_stream_if.source                  shown_out
);

    // width that holds any clock plus any base time without overflow
    localparam int WIDE = ((CLOCK_BITS > BASE_BITS) ? CLOCK_BITS : BASE_BITS) + 1;
    localparam logic [WIDE-1:0] CLOCK_MAX_WIDE =
        {{(WIDE-CLOCK_BITS){1'b0}}, {CLOCK_BITS{1'b1}}};
    localparam logic [CLOCK_BITS-1:0] RUN_FLOOR = CLOCK_BITS'(TICKS_PER_SECOND);
    localparam logic [CLOCK_BITS-1:0] ONE_TICK  = CLOCK_BITS'(1);
    localparam logic [MOVE_BITS-1:0]  ONE_MOVE  = MOVE_BITS'(1);

    function automatic logic [CLOCK_BITS-1:0] clip_clock(input logic [WIDE-1:0] value);
        logic [CLOCK_BITS-1:0] clipped;
        clipped = (value > CLOCK_MAX_WIDE) ? {CLOCK_BITS{1'b1}} : value[CLOCK_BITS-1:0];
        return clipped;
    endfunction

    function automatic logic [WIDE-1:0] widen_clock(input logic [CLOCK_BITS-1:0] value);
        return {{(WIDE-CLOCK_BITS){1'b0}}, value};
    endfunction

    // timing registers
    logic [BASE_BITS-1:0] base0_reg;
    logic [INC_BITS-1:0]  inc0_reg;
    logic [MOVE_BITS-1:0] limit0_reg;
    logic [BASE_BITS-1:0] base1_reg;
    logic [INC_BITS-1:0]  inc1_reg;
    logic [MOVE_BITS-1:0] limit1_reg;

    // game state
    logic [CLOCK_BITS-1:0] white_remaining_reg, white_remaining_next;
    logic [CLOCK_BITS-1:0] black_remaining_reg, black_remaining_next;
    logic [MOVE_BITS-1:0]  white_moves_reg, white_moves_next;
    logic [MOVE_BITS-1:0]  black_moves_reg, black_moves_next;
    logic                  stage_index_reg, stage_index_next;
    logic                  turn_reg, turn_next;
    logic                  running_reg, running_next;
    logic [CLOCK_BITS-1:0] shown_time_reg, shown_time_next;

    // a state update waiting to go into the time split
    logic    pending_reg;
    logic    split_ready;
    logic    in_fire;
    status_t pending_status;

    // per-tick working values
    logic [CLOCK_BITS-1:0] white_dec;
    logic [CLOCK_BITS-1:0] black_dec;
    logic [CLOCK_BITS-1:0] black_inc;
    logic [MOVE_BITS-1:0]  black_moves_inc;
    logic [INC_BITS-1:0]   inc_sel;
    logic [MOVE_BITS-1:0]  limit_sel;
    logic                  stage_end;
    logic [WIDE-1:0]       base1_wide;

    // a new tick may enter whenever the pending slot is empty or moving on
    assign move_in.ready = !pending_reg || split_ready;
    assign in_fire       = move_in.valid && move_in.ready;

    assign inc_sel    = (stage_index_reg == STAGE_ONE) ? inc1_reg : inc0_reg;
    assign limit_sel  = (stage_index_reg == STAGE_ONE) ? limit1_reg : limit0_reg;
    assign base1_wide = {{(WIDE-BASE_BITS){1'b0}}, base1_reg};

    always_comb
    begin
        white_remaining_next = white_remaining_reg;
        black_remaining_next = black_remaining_reg;
        white_moves_next     = white_moves_reg;
        black_moves_next     = black_moves_reg;
        stage_index_next     = stage_index_reg;
        turn_next            = turn_reg;
        running_next         = running_reg;
        shown_time_next      = shown_time_reg;

        // side to move counts down, stopping at zero
        white_dec = white_remaining_reg;
        black_dec = black_remaining_reg;
        if (turn_reg == SIDE_WHITE && white_remaining_reg != '0)
        begin
            white_dec = white_remaining_reg - ONE_TICK;
        end
        if (turn_reg == SIDE_BLACK && black_remaining_reg != '0)
        begin
            black_dec = black_remaining_reg - ONE_TICK;
        end

        black_inc = clip_clock(widen_clock(black_dec) +
                               {{(WIDE-INC_BITS){1'b0}}, inc_sel});
        black_moves_inc = black_moves_reg + ONE_MOVE;
        // stage ends only on a black move, once both counts sit at the limit
        stage_end = (limit_sel != '0) && (white_moves_reg == limit_sel) &&
                    (black_moves_inc == limit_sel);

        if (running_reg)
        begin
            white_remaining_next = white_dec;
            black_remaining_next = black_dec;
            shown_time_next      = (turn_reg == SIDE_BLACK) ? black_dec : white_dec;

            if (move_in.data.black_move_done && turn_reg == SIDE_BLACK)
            begin
                black_remaining_next = black_inc;
                black_moves_next     = black_moves_inc;
                if (stage_end)
                begin
                    stage_index_next     = STAGE_ONE;
                    white_remaining_next = clip_clock(widen_clock(white_dec) + base1_wide);
                    black_remaining_next = clip_clock(widen_clock(black_inc) + base1_wide);
                    white_moves_next     = '0;
                    black_moves_next     = '0;
                end
                shown_time_next = black_remaining_next;
                turn_next       = SIDE_WHITE;
            end
            else if (move_in.data.white_move_done && turn_reg == SIDE_WHITE)
            begin
                white_remaining_next = clip_clock(widen_clock(white_dec) +
                                                  {{(WIDE-INC_BITS){1'b0}}, inc_sel});
                white_moves_next     = white_moves_reg + ONE_MOVE;
                shown_time_next      = white_remaining_next;
                turn_next            = SIDE_BLACK;
            end

            // stop for good once either side is under one second
            running_next = !((white_remaining_next < RUN_FLOOR) ||
                             (black_remaining_next < RUN_FLOOR));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base0_reg           <= BASE0_RESET;
            inc0_reg            <= '0;
            limit0_reg          <= '0;
            base1_reg           <= '0;
            inc1_reg            <= '0;
            limit1_reg          <= '0;
            white_remaining_reg <= clip_clock({{(WIDE-BASE_BITS){1'b0}}, BASE0_RESET});
            black_remaining_reg <= clip_clock({{(WIDE-BASE_BITS){1'b0}}, BASE0_RESET});
            white_moves_reg     <= '0;
            black_moves_reg     <= '0;
            stage_index_reg     <= STAGE_ZERO;
            turn_reg            <= SIDE_WHITE;
            running_reg         <= 1'b1;
            shown_time_reg      <= '0;
            pending_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STAGE0_BASE:
                    begin
                        base0_reg           <= cfg_data[BASE_BITS-1:0];
                        // new starting time reloads both clocks
                        white_remaining_reg <= clip_clock({{(WIDE-BASE_BITS){1'b0}},
                                                           cfg_data[BASE_BITS-1:0]});
                        black_remaining_reg <= clip_clock({{(WIDE-BASE_BITS){1'b0}},
                                                           cfg_data[BASE_BITS-1:0]});
                    end
                    REG_STAGE0_INC:   inc0_reg   <= cfg_data[INC_BITS-1:0];
                    REG_STAGE0_LIMIT: limit0_reg <= cfg_data[MOVE_BITS-1:0];
                    REG_STAGE1_BASE:  base1_reg  <= cfg_data[BASE_BITS-1:0];
                    REG_STAGE1_INC:   inc1_reg   <= cfg_data[INC_BITS-1:0];
                    REG_STAGE1_LIMIT: limit1_reg <= cfg_data[MOVE_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
            else if (in_fire)
            begin
                white_remaining_reg <= white_remaining_next;
                black_remaining_reg <= black_remaining_next;
                white_moves_reg     <= white_moves_next;
                black_moves_reg     <= black_moves_next;
                stage_index_reg     <= stage_index_next;
                turn_reg            <= turn_next;
                running_reg         <= running_next;
                shown_time_reg      <= shown_time_next;
            end

            if (move_in.ready)
            begin
                pending_reg <= move_in.valid;
            end
        end
    end

    // the state registers themselves carry the pending result: they only
    // change on a transfer, which needs the pending slot to be free
    assign pending_status.side_to_move  = turn_reg;
    assign pending_status.clock_running = running_reg;
    assign pending_status.current_stage = stage_index_reg;

    tpgc_time_split #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .CLOCK_BITS       (CLOCK_BITS)
    ) u_time_split (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (pending_reg),
        .item_ready  (split_ready),
        .item_time   (shown_time_reg),
        .item_status (pending_status),
        .shown_out   (shown_out)
    );

endmodule

`default_nettype wire

FILE: sv/tpgc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tpgc_checker
    import tpgc_pkg::*;
(
    input wire logic   clk,
    input wire logic   rst_n,
    input wire logic   in_ready,
    input wire logic   out_valid,
    input wire logic   out_ready,
    input wire shown_t out_data
);

    logic   stopped_seen_reg;
    logic   stage_seen_reg;
    shown_t last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopped_seen_reg <= 1'b0;
            stage_seen_reg   <= 1'b0;
            last_reg         <= '0;
        end
        else if (out_valid && out_ready)
        begin
            last_reg <= out_data;
            if (!out_data.clock_running)
            begin
                stopped_seen_reg <= 1'b1;
            end
            if (out_data.current_stage == STAGE_ONE)
            begin
                stage_seen_reg <= 1'b1;
            end
        end
    end

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // input only stalls behind a full output
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.shown_minutes < 6'd60) && (out_data.shown_seconds < 6'd60))
        else $error("minutes or seconds out of range");

    // a stopped clock repeats its last result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stopped_seen_reg |-> !out_data.clock_running && (out_data == last_reg))
        else $error("stopped clock changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stage_seen_reg |-> out_data.current_stage == STAGE_ONE)
        else $error("stage went back");

endmodule

bind two_player_game_clock tpgc_checker u_tpgc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (move_in.ready),
    .out_valid (shown_out.valid),
    .out_ready (shown_out.ready),
    .out_data  (shown_out.data)
);

`default_nettype wire

FILE: verif/two_player_game_clock_tb.sv
`timescale 1ns / 1ps

module two_player_game_clock_tb;

    import tpgc_pkg::*;

    // clock rate and width of the block as instantiated
    localparam int TICKS_PER_SECOND = 100;
    localparam int CLOCK_BITS       = 24;
    localparam logic [CLOCK_BITS-1:0] CLOCK_MAX = '1;

    // the two indexes of the write port that name no register
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 3'd7;

    // cycles without any transfer before the run is given up
    localparam int STALL_LIMIT = 4000;
    // result latency of the block plus some margin
    localparam int DRAIN_CYCLES = 6;

    // ------------------------------------------------------------------
    // clock state model and queue of expected displays
    // ------------------------------------------------------------------
    class game_clock_checker;
        logic [BASE_BITS-1:0]  base_time[2];
        logic [INC_BITS-1:0]   increment[2];
        logic [MOVE_BITS-1:0]  move_limit[2];

        logic [CLOCK_BITS-1:0] white_left;
        logic [CLOCK_BITS-1:0] black_left;
        logic [MOVE_BITS-1:0]  white_moves;
        logic [MOVE_BITS-1:0]  black_moves;
        logic                  stage;
        logic                  turn;
        logic                  running;
        logic [CLOCK_BITS-1:0] shown;

        shown_t expected_displays[$];
        int     mismatches;

        function new();
            base_time[0]  = BASE0_RESET;
            base_time[1]  = '0;
            increment[0]  = '0;
            increment[1]  = '0;
            move_limit[0] = '0;
            move_limit[1] = '0;
            white_left    = BASE0_RESET;
            black_left    = BASE0_RESET;
            white_moves   = '0;
            black_moves   = '0;
            stage         = STAGE_ZERO;
            turn          = SIDE_WHITE;
            running       = 1'b1;
            shown         = '0;
            mismatches    = 0;
        endfunction

        function logic [CLOCK_BITS-1:0] add_sat(logic [CLOCK_BITS-1:0] a,
                                                logic [CLOCK_BITS-1:0] b);
            logic [CLOCK_BITS:0] sum;
            sum = {1'b0, a} + {1'b0, b};
            return sum[CLOCK_BITS] ? CLOCK_MAX : sum[CLOCK_BITS-1:0];
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                REG_STAGE0_BASE:
                begin
                    base_time[0] = val[BASE_BITS-1:0];
                    white_left   = val[BASE_BITS-1:0];
                    black_left   = val[BASE_BITS-1:0];
                end
                REG_STAGE0_INC:   increment[0]  = val[INC_BITS-1:0];
                REG_STAGE0_LIMIT: move_limit[0] = val[MOVE_BITS-1:0];
                REG_STAGE1_BASE:  base_time[1]  = val[BASE_BITS-1:0];
                REG_STAGE1_INC:   increment[1]  = val[INC_BITS-1:0];
                REG_STAGE1_LIMIT: move_limit[1] = val[MOVE_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void apply_tick(move_t m);
            shown_t      d;
            logic        s;
            int unsigned ticks;
            s = stage;
            if (running)
            begin
                if (turn == SIDE_WHITE)
                begin
                    if (white_left != 0) white_left = white_left - CLOCK_BITS'(1);
                    shown = white_left;
                end
                else
                begin
                    if (black_left != 0) black_left = black_left - CLOCK_BITS'(1);
                    shown = black_left;
                end

                if (m.black_move_done && turn == SIDE_BLACK)
                begin
                    black_left  = add_sat(black_left, CLOCK_BITS'(increment[s]));
                    black_moves = black_moves + MOVE_BITS'(1);
                    // stage end only looked at after a black move
                    if (move_limit[s] != 0 && white_moves == move_limit[s] &&
                        black_moves == move_limit[s])
                    begin
                        stage       = STAGE_ONE;
                        white_left  = add_sat(white_left, CLOCK_BITS'(base_time[STAGE_ONE]));
                        black_left  = add_sat(black_left, CLOCK_BITS'(base_time[STAGE_ONE]));
                        white_moves = '0;
                        black_moves = '0;
                    end
                    shown = black_left;
                    turn  = SIDE_WHITE;
                end
                else if (m.white_move_done && turn == SIDE_WHITE)
                begin
                    white_left  = add_sat(white_left, CLOCK_BITS'(increment[s]));
                    white_moves = white_moves + MOVE_BITS'(1);
                    shown       = white_left;
                    turn        = SIDE_BLACK;
                end

                if (white_left < CLOCK_BITS'(TICKS_PER_SECOND) ||
                    black_left < CLOCK_BITS'(TICKS_PER_SECOND))
                    running = 1'b0;
            end

            ticks = 32'(shown);
            d.shown_hours   = FIELD_BITS'(ticks / (TICKS_PER_SECOND * SECONDS_PER_HOUR));
            d.shown_minutes = FIELD_BITS'((ticks / (TICKS_PER_SECOND * SECONDS_PER_MINUTE))
                                          % MINUTES_PER_HOUR);
            d.shown_seconds = FIELD_BITS'((ticks / TICKS_PER_SECOND) % SECONDS_PER_MINUTE);
            d.side_to_move  = turn;
            d.clock_running = running;
            d.current_stage = stage;
            expected_displays.push_back(d);
        endfunction

        function void check_field(string name, logic [FIELD_BITS-1:0] want,
                                  logic [FIELD_BITS-1:0] got);
            if (want != got)
            begin
                mismatches++;
                $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_display(shown_t got);
            shown_t want;
            if (expected_displays.size() == 0)
            begin
                mismatches++;
                $display("%0t: display transfer with none expected, actual %p", $time, got);
                return;
            end
            want = expected_displays.pop_front();
            check_field("shown_hours", want.shown_hours, got.shown_hours);
            check_field("shown_minutes", want.shown_minutes, got.shown_minutes);
            check_field("shown_seconds", want.shown_seconds, got.shown_seconds);
            check_field("side_to_move", FIELD_BITS'(want.side_to_move),
                        FIELD_BITS'(got.side_to_move));
            check_field("clock_running", FIELD_BITS'(want.clock_running),
                        FIELD_BITS'(got.clock_running));
            check_field("current_stage", FIELD_BITS'(want.current_stage),
                        FIELD_BITS'(got.current_stage));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // block and its channels
    // ------------------------------------------------------------------
    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    tpgc_stream_if #(.payload_t(move_t))  move_if ();
    tpgc_stream_if #(.payload_t(shown_t)) shown_if ();

    two_player_game_clock #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .CLOCK_BITS       (CLOCK_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .move_in   (move_if),
        .shown_out (shown_if)
    );

    game_clock_checker sb;

    // when set, neither side holds back: a long stretch at full rate
    bit steady;
    int stalled_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // display side: random back-pressure, checking and the watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            shown_if.ready <= 1'b0;
            stalled_cycles <= 0;
        end
        else
        begin
            if (shown_if.valid && shown_if.ready)
                sb.check_display(shown_if.data);
            shown_if.ready <= steady || ($urandom_range(0, 99) >= 32);

            // any transfer on either side counts as progress
            if ((move_if.valid && move_if.ready) || (shown_if.valid && shown_if.ready))
                stalled_cycles <= 0;
            else if (stalled_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                stalled_cycles <= stalled_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // tick side
    // ------------------------------------------------------------------

    // one tick transfer, with random gaps ahead of it; valid is left high so
    // that back-to-back ticks never lower and raise it within one step
    task automatic send_tick(input move_t m);
        while (!steady && $urandom_range(0, 99) < 32)
        begin
            move_if.valid <= 1'b0;
            @(posedge clk);
        end
        move_if.valid <= 1'b1;
        move_if.data  <= m;
        @(posedge clk);
        while (!move_if.ready) @(posedge clk);
        sb.apply_tick(m);
    endtask

    // mostly the side to move pressing its own button, some noise on top
    task automatic play_ticks(input int count, input int press_pct);
        move_t m;
        for (int n = 0; n < count; n++)
        begin
            m = '0;
            if ($urandom_range(0, 99) < 15)
                m = move_t'($urandom_range(0, 3));
            else if ($urandom_range(0, 99) < press_pct)
            begin
                if (sb.turn == SIDE_BLACK)
                    m.black_move_done = 1'b1;
                else
                    m.white_move_done = 1'b1;
            end
            send_tick(m);
        end
    endtask

    // register writes only once the block has drained
    task automatic settle();
        move_if.valid <= 1'b0;
        while (sb.expected_displays.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        // opening ticks at the reset settings, as {black, white}: idle, a press by
        // the wrong side, both buttons at once, and plain alternating moves
        move_t opening[14] = '{2'b00, 2'b10, 2'b01, 2'b01, 2'b11, 2'b11, 2'b10,
                               2'b00, 2'b01, 2'b00, 2'b10, 2'b11, 2'b00, 2'b01};
        logic [MOVE_BITS-1:0] lim;

        sb             = new();
        steady         = 1'b0;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        move_if.valid  <= 1'b0;
        move_if.data   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
            send_tick(opening[i]);

        // largest starting time and increment: saturation of the clocks, top hours;
        // spare indexes must leave everything alone
        settle();
        write_reg(REG_STAGE0_BASE, CLOCK_MAX);
        write_reg(REG_STAGE0_INC, {8'($urandom), 16'hFFFF});
        write_reg(REG_SPARE_A, CFG_DATA_BITS'($urandom));
        write_reg(REG_SPARE_B, CFG_DATA_BITS'($urandom));
        play_ticks(60, 90);

        // full rate with dense moves, long enough for the move counts to wrap
        settle();
        steady = 1'b1;
        write_reg(REG_STAGE0_BASE, CFG_DATA_BITS'($urandom_range(2000, 24'hFFFFFF)));
        write_reg(REG_STAGE0_INC, CFG_DATA_BITS'($urandom_range(0, 3000)));
        play_ticks(540, 95);
        settle();
        steady = 1'b0;

        // widest stage-zero limit, no stage-one base time
        write_reg(REG_STAGE0_BASE, CFG_DATA_BITS'($urandom_range(2000, 24'hFFFFFF)));
        write_reg(REG_STAGE0_INC, CFG_DATA_BITS'($urandom));
        write_reg(REG_STAGE0_LIMIT, {16'($urandom), 8'hFF});
        write_reg(REG_STAGE1_BASE, '0);
        write_reg(REG_STAGE1_INC, CFG_DATA_BITS'($urandom_range(0, 500)));
        write_reg(REG_STAGE1_LIMIT, '0);
        play_ticks(250, 60);

        // limit set just ahead of the current count so stage one is entered,
        // then short stage-one limits keep restarting it
        settle();
        lim = sb.black_moves + MOVE_BITS'(2);
        if (lim == 0)
            lim = MOVE_BITS'(1);
        write_reg(REG_STAGE0_BASE, CFG_DATA_BITS'($urandom_range(5000, 24'hFFFFFF)));
        write_reg(REG_STAGE0_LIMIT, {16'($urandom), lim});
        write_reg(REG_STAGE1_BASE, CFG_DATA_BITS'($urandom_range(0, 24'hFFFFFF)));
        write_reg(REG_STAGE1_INC, CFG_DATA_BITS'($urandom_range(0, 16'hFFFF)));
        write_reg(REG_STAGE1_LIMIT, CFG_DATA_BITS'($urandom_range(1, 3)));
        play_ticks(300, 70);

        // stage one at its largest base time and increment: every restart saturates
        settle();
        write_reg(REG_STAGE1_BASE, CLOCK_MAX);
        write_reg(REG_STAGE1_INC, {8'($urandom), 16'hFFFF});
        write_reg(REG_STAGE1_LIMIT, CFG_DATA_BITS'(1));
        play_ticks(100, 80);

        // widest stage-one limit, moderate clocks
        settle();
        write_reg(REG_STAGE0_BASE, CFG_DATA_BITS'($urandom_range(3000, 200000)));
        write_reg(REG_STAGE1_BASE, CFG_DATA_BITS'($urandom_range(0, 50000)));
        write_reg(REG_STAGE1_INC, CFG_DATA_BITS'($urandom_range(0, 500)));
        write_reg(REG_STAGE1_LIMIT, {16'($urandom), 8'hFF});
        play_ticks(150, 70);

        settle();
        write_reg(REG_STAGE0_BASE, CFG_DATA_BITS'($urandom_range(2000, 100000)));
        write_reg(REG_STAGE0_INC, CFG_DATA_BITS'($urandom_range(0, 16'hFFFF)));
        write_reg(REG_STAGE1_BASE, CFG_DATA_BITS'($urandom_range(0, 2000)));
        write_reg(REG_STAGE1_INC, CFG_DATA_BITS'($urandom_range(0, 200)));
        write_reg(REG_STAGE1_LIMIT, CFG_DATA_BITS'($urandom_range(1, 4)));
        play_ticks(400, 60);

        // empty clocks: countdown holds at zero and the clock stops for good,
        // later ticks repeat the last display
        settle();
        write_reg(REG_STAGE0_BASE, '0);
        play_ticks(40, 50);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_displays.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
